@@ hw/rtl/projectile_bounce_step_defines.svh @@
// Assertion macros shared by the projectile bounce step RTL.
`ifndef PROJECTILE_BOUNCE_STEP_DEFINES_SVH
`define PROJECTILE_BOUNCE_STEP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pbs_pkg.sv @@
// Types and constants of the projectile bounce step block.
package pbs_pkg;

	localparam int MUL_A_W  = 36;
	localparam int MUL_B_W  = 16;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int DVD_W    = 64;
	localparam int DVS_W    = 32;
	localparam int QUO_W    = 35;
	localparam int CNT_W    = 6;

	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_COLLIDE = 2'd1;
	localparam logic [1:0] REQ_LAUNCH  = 2'd2;

	localparam logic [2:0] CFG_GRAVITY = 3'd0;
	localparam logic [2:0] CFG_DAMPING = 3'd1;
	localparam logic [2:0] CFG_MAX_BNC = 3'd2;
	localparam logic [2:0] CFG_X_LIMIT = 3'd3;
	localparam logic [2:0] CFG_Y_LIMIT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_NN_MUL,
		S_NN_ACC,
		S_DOT_MUL,
		S_DOT_ACC,
		S_Q_LO,
		S_Q_HI,
		S_Q_SUM,
		S_DIV,
		S_R,
		S_DAMP,
		S_AXIS,
		S_COMMIT,
		S_DONE
	} pbs_state_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		hi = 38'sd2147483647;
		lo = -38'sd2147483648;
		if (v > hi) sat32 = 32'sh7fffffff;
		else if (v < lo) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

endpackage

@@ hw/rtl/pbs_mul.sv @@
// Shared unsigned multiplier with a registered product.
module pbs_mul (
	input  logic                        clk,
	input  logic [pbs_pkg::MUL_A_W-1:0] a,
	input  logic [pbs_pkg::MUL_B_W-1:0] b,
	output logic [pbs_pkg::PROD_W-1:0]  prod
);
	import pbs_pkg::*;

	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_s1;
endmodule

@@ hw/rtl/pbs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pbs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pbs_pkg::DVD_W-1:0] dvd,
	input  logic [pbs_pkg::DVS_W-1:0] dvs,
	output logic                      busy,
	output logic [pbs_pkg::QUO_W-1:0] quo
);
	import pbs_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] shf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// Quotient is known to stay below 2^QUO_W, so the top bits seed the remainder.
	assign trial = {rem_q, shf_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DVS_W'(dvd[DVD_W-1:QUO_W]);
			shf_q <= dvd[QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
			shf_q <= {shf_q[QUO_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = shf_q;
endmodule

@@ hw/rtl/projectile_bounce_step.sv @@
// Top level of the projectile bounce step block: sequencer and state.
//
// Keeps one Q16.16 projectile. Each input transaction on the s_ group carries
// a request (tick, collision, launch) in s_tuser and its operands in s_tdata;
// each produces exactly one output transaction on the m_ group holding the
// state after the step. The user must write configuration through cfg_we/
// cfg_addr/cfg_wdata only while no request is in flight; no check enforces it.
//
// A tick, a launch or an unused request code passes through S_EXEC and
// S_DONE. A collision also runs the n.n and v.n multiplier passes, then
// per axis the two d*n partial products, a division by the shared
// divider (one quotient bit a cycle), the damping product and the axis
// write, and finally S_COMMIT. A zero normal skips the divider. The result
// is loaded into the output register on leaving S_DONE. s_tready is high
// only while the sequencer is idle; one request is worked on at a time.
//
// Reset clears position, velocity, count and alive flag and loads the
// register defaults. A stalled receiver holds the result in the output
// register; the next request may be accepted meanwhile, and its result
// waits until the held transaction is taken.
module projectile_bounce_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_z, launch_vx, launch_vy, launch_vz,
	// normal_x, normal_y, normal_z
	input  logic [239:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z,
	// is_alive, bounce_total, zero fill
	output logic [199:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [30:0]  cfg_wdata
);
	import pbs_pkg::*;

	pbs_state_t state_q, state_d;

	// configuration
	logic [15:0] gravity_q, damping_q;
	logic [3:0]  max_bnc_q;
	logic [30:0] x_limit_q, y_limit_q;

	// projectile state
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] nv_q  [3];
	logic [3:0]         count_q;
	logic               alive_q;

	// latched request
	logic [1:0]         req_q;
	logic signed [31:0] in_pos_q [3];
	logic signed [31:0] in_vel_q [3];
	logic signed [15:0] nrm_q    [3];

	// collision datapath
	logic [1:0]         k_q;
	logic [31:0]        nn_q;
	logic signed [49:0] d_q;
	logic               psign_q;
	logic [39:0]        qlo_q;
	logic               qsign_q;
	logic [35:0]        rmag_q;
	logic               rneg_q;

	logic                  out_valid_q;
	logic [199:0]          out_data_q;

	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PROD_W-1:0]     prod;
	logic                  div_start;
	logic                  div_busy;
	logic [QUO_W-1:0]      quo;
	logic [DVD_W-1:0]      dvd;

	logic signed [15:0]    nk;
	logic [15:0]           nmag;
	logic signed [31:0]    vk;
	logic [31:0]           vmag;
	logic [47:0]           dmag;
	logic signed [36:0]    r_val;
	logic [36:0]           s_val;
	logic signed [37:0]    axis_val;
	logic                  out_free;

	logic signed [31:0]    vy_tick;
	logic signed [31:0]    px_tick, py_tick, pz_tick;
	logic signed [32:0]    xl, yl;
	logic                  kill;

	pbs_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (dvd),
		.dvs    (nn_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	// Per-axis operand selection.
	assign nk   = nrm_q[k_q];
	assign nmag = nk[15] ? 16'(-nk) : 16'(nk);
	assign vk   = vel_q[k_q];
	assign vmag = vk[31] ? 32'(-vk) : 32'(vk);
	assign dmag = d_q[49] ? 48'(-d_q) : d_q[47:0];

	// Rounded dividend 2|d*n_k| + nn/2 from the two partial products.
	assign dvd = ((64'(qlo_q) + {prod[39:0], 24'b0}) << 1) + 64'(nn_q >> 1);

	// r = v_k - delta, or -v_k for a zero normal.
	always_comb begin
		if (nn_q == '0) r_val = -37'(vk);
		else if (qsign_q) r_val = 37'(vk) + 37'(quo);
		else r_val = 37'(vk) - 37'(quo);
	end

	assign s_val    = 37'((53'(prod) + 53'h8000) >> 16);
	assign axis_val = rneg_q ? -38'(s_val) : 38'(s_val);

	// Tick motion; limits compare as signed against the moved position.
	assign vy_tick = sat32(38'(vel_q[1]) - 38'(gravity_q));
	assign px_tick = sat32(38'(pos_q[0]) + 38'(vel_q[0]));
	assign py_tick = sat32(38'(pos_q[1]) + 38'(vy_tick));
	assign pz_tick = sat32(38'(pos_q[2]) + 38'(vel_q[2]));
	assign xl = $signed({2'b0, x_limit_q});
	assign yl = $signed({2'b0, y_limit_q});
	assign kill = (count_q >= max_bnc_q)
		|| (33'(px_tick) >= xl)
		|| (33'(px_tick) <= -xl)
		|| (33'(py_tick) >= yl);

	assign out_free = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (s_tvalid) state_d = S_EXEC;
			S_EXEC:    state_d = (req_q == REQ_COLLIDE) ? S_NN_MUL : S_DONE;
			S_NN_MUL:  state_d = S_NN_ACC;
			S_NN_ACC:  state_d = (k_q == 2'd2) ? S_DOT_MUL : S_NN_MUL;
			S_DOT_MUL: state_d = S_DOT_ACC;
			S_DOT_ACC: state_d = (k_q == 2'd2) ? S_Q_LO : S_DOT_MUL;
			S_Q_LO:    state_d = S_Q_HI;
			S_Q_HI:    state_d = S_Q_SUM;
			S_Q_SUM:   state_d = (nn_q == '0) ? S_R : S_DIV;
			S_DIV:     if (!div_busy) state_d = S_R;
			S_R:       state_d = S_DAMP;
			S_DAMP:    state_d = S_AXIS;
			S_AXIS:    state_d = (k_q == 2'd2) ? S_COMMIT : S_Q_LO;
			S_COMMIT:  state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Control outputs: multiplier operands, divider start, input ready.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_NN_MUL: begin
				mul_a = MUL_A_W'(nmag);
				mul_b = nmag;
			end
			S_DOT_MUL: begin
				mul_a = MUL_A_W'(vmag);
				mul_b = nmag;
			end
			S_Q_LO: begin
				mul_a = MUL_A_W'(dmag[23:0]);
				mul_b = nmag;
			end
			S_Q_HI: begin
				mul_a = MUL_A_W'(dmag[47:24]);
				mul_b = nmag;
			end
			S_Q_SUM: div_start = (nn_q != '0);
			S_DAMP: begin
				mul_a = rmag_q;
				mul_b = damping_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			gravity_q   <= 16'd655;
			damping_q   <= 16'd58982;
			max_bnc_q   <= 4'd8;
			x_limit_q   <= 31'd2621440;
			y_limit_q   <= 31'd3932160;
			count_q     <= '0;
			alive_q     <= 1'b0;
			pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
			vel_q[0] <= '0; vel_q[1] <= '0; vel_q[2] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					CFG_GRAVITY: gravity_q <= cfg_wdata[15:0];
					CFG_DAMPING: damping_q <= cfg_wdata[15:0];
					CFG_MAX_BNC: max_bnc_q <= cfg_wdata[3:0];
					CFG_X_LIMIT: x_limit_q <= cfg_wdata;
					CFG_Y_LIMIT: y_limit_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == S_EXEC) begin
				if (req_q == REQ_LAUNCH) begin
					pos_q   <= in_pos_q;
					vel_q   <= in_vel_q;
					count_q <= '0;
					alive_q <= 1'b1;
				end else if (req_q == REQ_TICK) begin
					vel_q[1] <= vy_tick;
					pos_q[0] <= px_tick;
					pos_q[1] <= py_tick;
					pos_q[2] <= pz_tick;
					if (kill) alive_q <= 1'b0;
				end
			end
			if (state_q == S_COMMIT) begin
				vel_q <= nv_q;
				if (count_q != 4'hf) count_q <= count_q + 1'b1;
			end
			// Hold a stalled result; load a new one once the slot frees.
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q       <= s_tuser;
			in_pos_q[0] <= s_tdata[31:0];
			in_pos_q[1] <= s_tdata[63:32];
			in_pos_q[2] <= s_tdata[95:64];
			in_vel_q[0] <= s_tdata[127:96];
			in_vel_q[1] <= s_tdata[159:128];
			in_vel_q[2] <= s_tdata[191:160];
			nrm_q[0]    <= s_tdata[207:192];
			nrm_q[1]    <= s_tdata[223:208];
			nrm_q[2]    <= s_tdata[239:224];
		end
		case (state_q)
			S_EXEC: begin
				k_q  <= '0;
				nn_q <= '0;
				d_q  <= '0;
			end
			S_NN_ACC: begin
				nn_q <= nn_q + prod[31:0];
				k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
			end
			S_DOT_MUL: psign_q <= vk[31] ^ nk[15];
			S_DOT_ACC: begin
				d_q <= psign_q ? d_q - 50'(prod) : d_q + 50'(prod);
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
			end
			S_Q_HI: qlo_q <= prod[39:0];
			S_Q_SUM: qsign_q <= d_q[49] ^ nk[15];
			S_R: begin
				rneg_q <= r_val[36];
				rmag_q <= r_val[36] ? 36'(-r_val) : r_val[35:0];
			end
			S_AXIS: begin
				nv_q[k_q] <= sat32(axis_val);
				k_q       <= k_q + 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= {3'b0, count_q, alive_q,
						vel_q[2], vel_q[1], vel_q[0],
						pos_q[2], pos_q[1], pos_q[0]};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`include "projectile_bounce_step_defines.svh"

	`PBS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted while busy")
	`PBS_ASSERT_NOW(a_div_in_div_state, div_busy, state_q == S_DIV, "divider runs outside divide step")
	`PBS_ASSERT_NOW(a_alive_from_launch, $rose(alive_q), $past(req_q == REQ_LAUNCH), "alive set without launch")
	`PBS_ASSERT_NEXT(a_collision_counts, state_q == S_COMMIT && count_q != 4'hf, count_q == $past(count_q) + 4'd1, "bounce count not advanced")

endmodule

@@ tb/sv/projectile_bounce_step_tb.sv @@
// Self-checking testbench for the projectile bounce step block.
`timescale 1ns / 100ps

module projectile_bounce_step_tb;
	import pbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 200;
	localparam int N_RANDOM       = 1650;

	// One request as it travels on the slave side.
	typedef struct {
		logic [1:0]         req;
		logic signed [31:0] sx, sy, sz, lvx, lvy, lvz;
		logic signed [15:0] nx, ny, nz;
	} request_t;

	// One projectile snapshot as it travels on the master side.
	typedef struct packed {
		logic [3:0]         bounces;
		logic               alive;
		logic signed [31:0] vz, vy, vx, pz, py, px;
	} snapshot_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [239:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [199:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_addr = '0;
	logic [30:0]  cfg_wdata = '0;

	projectile_bounce_step dut (.*);

	always #4 clk = ~clk;

	// Predictor state: configuration and projectile.
	longint g_step, damp, max_bnc, x_lim, y_lim;
	longint p_x, p_y, p_z, v_x, v_y, v_z;
	int     bnc;
	bit     live;

	snapshot_t expected_snaps[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        timed_out = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Damped reflection of one velocity axis; the rounding runs unsigned.
	function automatic longint reflect_axis(longint vk, longint nk, longint d, longint nn);
		longint r, q, s;
		longint unsigned mq, mm, nnu;
		r = -vk;
		if (nn != 0) begin
			q = d * nk;
			mq = (q < 0) ? -q : q;
			nnu = nn;
			mm = (2 * mq + nnu / 2) / nnu;
			r = vk - (q < 0 ? -longint'(mm) : longint'(mm));
		end
		s = ((r < 0 ? -r : r) * damp + 64'h8000) >>> 16;
		return clamp32(r < 0 ? -s : s);
	endfunction

	function automatic void predict_reset();
		g_step = 655; damp = 58982; max_bnc = 8; x_lim = 2621440; y_lim = 3932160;
		p_x = 0; p_y = 0; p_z = 0; v_x = 0; v_y = 0; v_z = 0;
		bnc = 0; live = 0;
	endfunction

	// Advance the projectile by one request and return the snapshot after it.
	function automatic snapshot_t predict_step(request_t r);
		snapshot_t s;
		longint nx, ny, nz, nn, d, ax, ay, az;
		case (r.req)
			REQ_LAUNCH: begin
				p_x = r.sx; p_y = r.sy; p_z = r.sz;
				v_x = r.lvx; v_y = r.lvy; v_z = r.lvz;
				bnc = 0; live = 1;
			end
			REQ_TICK: begin
				v_y = clamp32(v_y - g_step);
				p_x = clamp32(p_x + v_x);
				p_y = clamp32(p_y + v_y);
				p_z = clamp32(p_z + v_z);
				if (bnc >= max_bnc) live = 0;
				if (p_x >= x_lim || p_x <= -x_lim) live = 0;
				if (p_y >= y_lim) live = 0;
			end
			REQ_COLLIDE: begin
				nx = r.nx; ny = r.ny; nz = r.nz;
				nn = nx * nx + ny * ny + nz * nz;
				d = v_x * nx + v_y * ny + v_z * nz;
				ax = reflect_axis(v_x, nx, d, nn);
				ay = reflect_axis(v_y, ny, d, nn);
				az = reflect_axis(v_z, nz, d, nn);
				v_x = ax; v_y = ay; v_z = az;
				if (bnc < 15) bnc++;
			end
			default: ;
		endcase
		s.px = p_x[31:0]; s.py = p_y[31:0]; s.pz = p_z[31:0];
		s.vx = v_x[31:0]; s.vy = v_y[31:0]; s.vz = v_z[31:0];
		s.alive = live; s.bounces = bnc[3:0];
		return s;
	endfunction

	// Directed table: typed expectation applies only where has_snap is set.
	typedef struct {
		request_t  rq;
		bit        has_snap;
		snapshot_t snap;
	} directed_row_t;

	directed_row_t directed_rows[$];

	function automatic request_t mk_req(logic [1:0] t, longint sx, longint sy, longint sz,
			longint vx, longint vy, longint vz, int nx, int ny, int nz);
		request_t r;
		r.req = t; r.sx = 32'(sx); r.sy = 32'(sy); r.sz = 32'(sz);
		r.lvx = 32'(vx); r.lvy = 32'(vy); r.lvz = 32'(vz);
		r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
		return r;
	endfunction

	function automatic void add_row(request_t r, bit has, snapshot_t s);
		directed_row_t row;
		row.rq = r; row.has_snap = has; row.snap = s;
		directed_rows.push_back(row);
	endfunction

	function automatic request_t rand_request();
		request_t r;
		int k;
		k = $urandom_range(99);
		if (k < 12) r.req = REQ_LAUNCH;
		else if (k < 75) r.req = REQ_TICK;
		else if (k < 97) r.req = REQ_COLLIDE;
		else r.req = 2'd3;
		// Launches mostly land inside the arena so ticks have room to fly.
		if ($urandom_range(3) == 0) begin
			r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
			r.lvx = $urandom; r.lvy = $urandom; r.lvz = $urandom;
		end else begin
			r.sx = $signed($urandom_range(2000000)) - 1000000;
			r.sy = $signed($urandom_range(2000000)) - 1000000;
			r.sz = $urandom;
			r.lvx = $signed($urandom_range(200000)) - 100000;
			r.lvy = $signed($urandom_range(200000)) - 100000;
			r.lvz = $signed($urandom_range(200000)) - 100000;
		end
		if ($urandom_range(9) == 0) begin
			r.nx = '0; r.ny = '0; r.nz = '0;
		end else begin
			r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
			if ($urandom_range(1)) begin
				r.nx = r.nx >>> 8; r.ny = r.ny >>> 8; r.nz = r.nz >>> 8;
			end
		end
		return r;
	endfunction

	// Send one transaction, holding valid across bursts.
	task automatic send_request(request_t r, bit keep_valid);
		s_tdata  <= {r.nz, r.ny, r.nx, r.lvz, r.lvy, r.lvx, r.sz, r.sy, r.sx};
		s_tuser  <= r.req;
		s_tvalid <= 1'b1;
		expected_snaps.push_back(predict_step(r));
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (!keep_valid) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, longint val);
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val[30:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_GRAVITY: g_step  = val & 16'hFFFF;
			CFG_DAMPING: damp    = val & 16'hFFFF;
			CFG_MAX_BNC: max_bnc = val & 4'hF;
			CFG_X_LIMIT: x_lim   = val & 31'h7FFFFFFF;
			CFG_Y_LIMIT: y_lim   = val & 31'h7FFFFFFF;
			default: ;
		endcase
	endtask

	// Wait for every expected snapshot to drain, plus the pipeline tail.
	task automatic drain();
		while (expected_snaps.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic random_burst(int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			for (int i = 0; i < burst; i++) send_request(rand_request(), i != burst - 1);
			left -= burst;
			if ($urandom_range(2) != 0) repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// Receiver stalls: open windows of random length, most followed by a stall window of random length.
	initial begin : receiver_pattern
		int run;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= 1'b1;
			run = $urandom_range(1, 40);
			repeat (run) @(negedge clk);
			if ($urandom_range(3) != 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// Compare each accepted snapshot with the oldest expectation.
	always @(posedge clk) begin
		snapshot_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[196:0];
			if (expected_snaps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_snaps.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pos %h %h %h vel %h %h %h alive %b cnt %0d\n          actual   pos %h %h %h vel %h %h %h alive %b cnt %0d",
							want.px, want.py, want.pz, want.vx, want.vy, want.vz,
							want.alive, want.bounces, got.px, got.py, got.pz,
							got.vx, got.vy, got.vz, got.alive, got.bounces);
				end
			end
		end
	end

	// Watchdog: count cycles in which nothing is accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		snapshot_t s;
		predict_reset();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// After reset: a tick on a dead, resting projectile only sinks by gravity.
		s = '0; s.vy = -655; s.py = -655;
		add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, s);
		s = '0; s.alive = 1; s.px = 32'h7fffffff; s.py = 32'h80000000; s.pz = 32'h7fffffff;
		s.vx = 32'h7fffffff; s.vy = 32'h80000000; s.vz = 32'h80000000;
		add_row(mk_req(REQ_LAUNCH, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 0), 1, s);
		// Saturating motion and limits at the extremes.
		add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);
		add_row(mk_req(REQ_LAUNCH, 0, 0, 0, 65536, 131072, -65536, 0, 0, 0), 0, s);
		// Zero normal reverses and damps; then nonzero and extreme normals, a tick and an unused code.
		add_row(mk_req(REQ_COLLIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);
		add_row(mk_req(REQ_COLLIDE, 0, 0, 0, 0, 0, 0, 0, 256, 0), 0, s);
		add_row(mk_req(REQ_COLLIDE, 0, 0, 0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff), 0, s);
		add_row(mk_req(REQ_COLLIDE, 0, 0, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000), 0, s);
		add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);
		add_row(mk_req(2'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);
		// Zero velocity at a collision, then drive the count to saturation.
		add_row(mk_req(REQ_LAUNCH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);
		for (int i = 0; i < 16; i++)
			add_row(mk_req(REQ_COLLIDE, 0, 0, 0, 0, 0, 0, 128, -300, 5), 0, s);
		add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, s);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].rq, 1'b0);
			if (directed_rows[i].has_snap && expected_snaps[$] !== directed_rows[i].snap) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d disagrees with prediction: %h vs %h",
						i, directed_rows[i].snap, expected_snaps[$]);
			end
		end
		drain();

		// Random phases, each under a different register setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(CFG_GRAVITY, 65535); write_reg(CFG_DAMPING, 65535);
					write_reg(CFG_MAX_BNC, 15); write_reg(CFG_X_LIMIT, 31'h7fffffff);
					write_reg(CFG_Y_LIMIT, 31'h7fffffff);
				end
				2: begin
					write_reg(CFG_GRAVITY, 0); write_reg(CFG_DAMPING, 0);
					write_reg(CFG_MAX_BNC, 1); write_reg(CFG_X_LIMIT, 0);
					write_reg(CFG_Y_LIMIT, 0);
				end
				default: begin
					write_reg(CFG_GRAVITY, $urandom_range(65535));
					write_reg(CFG_DAMPING, $urandom_range(65535));
					write_reg(CFG_MAX_BNC, $urandom_range(1, 15));
					write_reg(CFG_X_LIMIT, $urandom_range(1 << 20, 1 << 24));
					write_reg(CFG_Y_LIMIT, $urandom_range(1 << 20, 1 << 24));
				end
			endcase
			random_burst(N_RANDOM / 6);
			drain();
		end

		if (mismatches == 0 && expected_snaps.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
